@@ rtl/rclcfp_pkg.sv @@
// rclcfp_pkg: shared types and constants for the rc link channel frame parser
// no dependencies

package rclcfp_pkg;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_LEN     = 2'd1,
    PH_TYPE    = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_e;

  localparam logic [7:0] SYNC_BYTE = 8'hC8;
  localparam logic [7:0] RC_TYPE   = 8'h16;

  localparam int unsigned CH_BITS  = 11;
  localparam int unsigned ACC_BITS = 18;
  localparam int unsigned HELD_BITS = 5;

  localparam logic [CH_BITS-1:0] RAW_MIN = 11'd172;
  localparam logic [CH_BITS-1:0] RAW_MAX = 11'd1811;
  localparam logic [CH_BITS-1:0] OUT_MIN = 11'd1000;
  localparam logic [CH_BITS-1:0] OUT_MAX = 11'd2000;

  // floor(d * 1000 / 1639) == (d * SCALE_MUL) >> SCALE_SHIFT for d in 0..1639
  localparam logic [21:0] SCALE_MUL   = 22'd2559063;
  localparam int unsigned SCALE_SHIFT = 22;

  localparam logic [HELD_BITS-1:0] BYTE_BITS = 5'd8;
  localparam logic [HELD_BITS-1:0] CH_WIDTH  = 5'd11;

  // configuration register indexes
  localparam logic [1:0] REG_ROLL     = 2'd0;
  localparam logic [1:0] REG_PITCH    = 2'd1;
  localparam logic [1:0] REG_THROTTLE = 2'd2;
  localparam logic [1:0] REG_YAW      = 2'd3;

  // stick channel numbers
  localparam logic [4:0] CH_ROLL     = 5'd0;
  localparam logic [4:0] CH_PITCH    = 5'd1;
  localparam logic [4:0] CH_THROTTLE = 5'd2;
  localparam logic [4:0] CH_YAW      = 5'd3;

endpackage

@@ rtl/rc_link_channel_frame_parser.sv @@
// rc_link_channel_frame_parser: rc channels frame parser, top level
// depends on rclcfp_pkg and rclcfp_scale
// path: a byte taken into the input register is parsed there and its result is
// captured in the output register; a held output stalls the input as well
// throughput: one byte per cycle unless stalled, set by the single parse stage and output register
// reset: asynchronous; hunts for sync, slots 0..3, accumulator and counts cleared

module rc_link_channel_frame_parser import rclcfp_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [2:0]   cfg_data_i,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [7:0]   rx_byte_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [2:0]   slot_o,
  output logic [10:0]  pulse_value_o,
  output logic         frame_done_o
);

  localparam int unsigned CntW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CntW-1:0] LastCh = CntW'(NUM_CHANNELS - 1);

  logic [2:0] roll_slot_q, pitch_slot_q, throttle_slot_q, yaw_slot_q;

  logic       in_valid_q;
  logic [7:0] byte_q;

  phase_e                phase_q, phase_d;
  logic [ACC_BITS-1:0]   acc_q, acc_d;
  logic [HELD_BITS-1:0]  held_q, held_d;
  logic [CntW-1:0]       cnt_q, cnt_d;

  logic        out_valid_q;
  logic [2:0]  slot_q;
  logic [10:0] pulse_q;
  logic        done_q;

  logic                 advance;
  logic                 process;
  logic                 emit;
  logic [ACC_BITS-1:0]  acc_new;
  logic [HELD_BITS-1:0] held_new;
  logic [CH_BITS-1:0]   raw;
  logic [CH_BITS-1:0]   pulse;
  logic [2:0]           slot;
  logic                 last;
  logic [4:0]           ch_wide;

  assign advance    = !out_valid_q || !out_stall_i;
  assign process    = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_slot_q     <= 3'd0;
      pitch_slot_q    <= 3'd1;
      throttle_slot_q <= 3'd2;
      yaw_slot_q      <= 3'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROLL:     roll_slot_q     <= cfg_data_i;
        REG_PITCH:    pitch_slot_q    <= cfg_data_i;
        REG_THROTTLE: throttle_slot_q <= cfg_data_i;
        REG_YAW:      yaw_slot_q      <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= rx_byte_i;
    end
  end

  // parse
  assign acc_new  = acc_q | (ACC_BITS'(byte_q) << held_q[3:0]);
  assign held_new = held_q + BYTE_BITS;
  assign raw      = acc_new[CH_BITS-1:0];
  assign last     = (cnt_q == LastCh);
  assign ch_wide  = 5'(cnt_q);

  always_comb begin
    unique case (ch_wide)
      CH_ROLL:     slot = roll_slot_q;
      CH_PITCH:    slot = pitch_slot_q;
      CH_THROTTLE: slot = throttle_slot_q;
      CH_YAW:      slot = yaw_slot_q;
      default:     slot = ch_wide[2:0];
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    held_d  = held_q;
    cnt_d   = cnt_q;
    emit    = 1'b0;
    unique case (phase_q)
      PH_HUNT: begin
        if (byte_q == SYNC_BYTE) phase_d = PH_LEN;
      end
      PH_LEN: begin
        phase_d = PH_TYPE;
      end
      PH_TYPE: begin
        if (byte_q == RC_TYPE) begin
          phase_d = PH_PAYLOAD;
          acc_d   = '0;
          held_d  = '0;
          cnt_d   = '0;
        end else if (byte_q == SYNC_BYTE) begin
          phase_d = PH_LEN;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        if (held_new < CH_WIDTH) begin
          acc_d  = acc_new;
          held_d = held_new;
        end else begin
          emit = 1'b1;
          if (last) begin
            phase_d = PH_HUNT;
            acc_d   = '0;
            held_d  = '0;
            cnt_d   = '0;
          end else begin
            acc_d  = acc_new >> CH_BITS;
            held_d = held_new - CH_WIDTH;
            cnt_d  = cnt_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  rclcfp_scale u_scale (
    .raw_i   (raw),
    .pulse_o (pulse)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      acc_q   <= '0;
      held_q  <= '0;
      cnt_q   <= '0;
    end else if (process) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      held_q  <= held_d;
      cnt_q   <= cnt_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= process && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process && emit) begin
      slot_q  <= slot;
      pulse_q <= pulse;
      done_q  <= last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign slot_o        = slot_q;
  assign pulse_value_o = pulse_q;
  assign frame_done_o  = done_q;

`ifndef SYNTHESIS
  a_pulse_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pulse_value_o >= OUT_MIN) && (pulse_value_o <= OUT_MAX))
    else $error("pulse value out of range");

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q < CH_WIDTH)
    else $error("bit count exceeds one channel");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(phase_q) && $stable(cnt_q) && $stable(held_q))
    else $error("parser state moved while stalled");
`endif

endmodule

@@ rtl/rclcfp_scale.sv @@
// rclcfp_scale: clamps a raw 11-bit channel and scales it to the pulse range
// depends on rclcfp_pkg

module rclcfp_scale import rclcfp_pkg::*; (
  input  logic [CH_BITS-1:0] raw_i,
  output logic [CH_BITS-1:0] pulse_o
);

  logic [CH_BITS-1:0] clamped;
  logic [CH_BITS-1:0] offset;
  logic [32:0]        prod;

  always_comb begin
    priority if (raw_i < RAW_MIN) begin
      clamped = RAW_MIN;
    end else if (raw_i > RAW_MAX) begin
      clamped = RAW_MAX;
    end else begin
      clamped = raw_i;
    end
    offset  = clamped - RAW_MIN;
    prod    = 33'(offset) * 33'(SCALE_MUL);
    pulse_o = OUT_MIN + prod[SCALE_SHIFT +: CH_BITS];
  end

endmodule
